// File: rtl/core/matrix3_inverse_unit_macros.svh
// assertion macros for the 3x3 matrix inverse unit
`ifndef MATRIX3_INVERSE_UNIT_MACROS_SVH
`define MATRIX3_INVERSE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define M3INV_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define M3INV_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: rtl/core/m3inv_pkg.sv
// shared types and constants of the 3x3 matrix inverse unit
package m3inv_pkg;

	// entry width of every matrix and result entry
	localparam int ENTRY_W = 32;

	typedef struct packed {
		logic signed [ENTRY_W-1:0] a00;
		logic signed [ENTRY_W-1:0] a01;
		logic signed [ENTRY_W-1:0] a02;
		logic signed [ENTRY_W-1:0] a10;
		logic signed [ENTRY_W-1:0] a11;
		logic signed [ENTRY_W-1:0] a12;
		logic signed [ENTRY_W-1:0] a20;
		logic signed [ENTRY_W-1:0] a21;
		logic signed [ENTRY_W-1:0] a22;
	} operand_t;

	typedef struct packed {
		logic signed [ENTRY_W-1:0] r00;
		logic signed [ENTRY_W-1:0] r01;
		logic signed [ENTRY_W-1:0] r02;
		logic signed [ENTRY_W-1:0] r10;
		logic signed [ENTRY_W-1:0] r11;
		logic signed [ENTRY_W-1:0] r12;
		logic signed [ENTRY_W-1:0] r20;
		logic signed [ENTRY_W-1:0] r21;
		logic signed [ENTRY_W-1:0] r22;
		logic                      singular;
	} result_t;

endpackage

// File: rtl/core/matrix3_inverse_unit.sv
// Pipelined 3x3 fixed-point matrix inverse (adjugate over determinant).
// One item (a whole matrix) can be started in every cycle; busy stays low. Each result
// appears on result for exactly one cycle with done high. Nine parallel divider lanes
// resolve one quotient bit per pipeline stage, behind the stages of products,
// cofactors, determinant and magnitudes. The receiver cannot stall the unit, so every
// result must be taken in its cycle. A matrix with a zero determinant returns all-zero
// entries with singular set; quotients out of range saturate to the entry range.
module matrix3_inverse_unit
	import m3inv_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  operand_t operand,
	output logic     done,
	output result_t  result
);

`include "matrix3_inverse_unit_macros.svh"

	localparam int W   = ENTRY_W;
	localparam int PW  = 2 * W;
	localparam int CW  = 2 * W + 1;
	localparam int TW  = 3 * W + 1;
	localparam int DW  = 3 * W + 3;
	localparam int XW  = DW + W + 1;
	localparam int LAT = W + 9;

	// product operand indexes: cofactor i = p[2i] - p[2i+1]
	localparam int PA [18] = '{4, 7, 2, 1, 1, 2, 5, 3, 0, 2, 3, 0, 3, 6, 6, 0, 0, 3};
	localparam int PB [18] = '{8, 5, 7, 8, 5, 4, 6, 8, 8, 6, 2, 5, 7, 4, 1, 7, 4, 1};
	// first-column adjugate entries (first-row cofactors) for the determinant
	localparam int DC [3] = '{0, 3, 6};

	localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};

	// never stalls
	assign busy = 1'b0;

	logic                accept;
	logic signed [W-1:0] a_in [9];

	assign accept = start && !busy;

	// unpack the matrix
	always_comb begin
		a_in[0] = operand.a00;
		a_in[1] = operand.a01;
		a_in[2] = operand.a02;
		a_in[3] = operand.a10;
		a_in[4] = operand.a11;
		a_in[5] = operand.a12;
		a_in[6] = operand.a20;
		a_in[7] = operand.a21;
		a_in[8] = operand.a22;
	end

	// valid bits of the front stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	logic signed [W-1:0]  a_s1 [9];
	logic signed [PW-1:0] p_s2 [18];
	logic signed [W-1:0]  a_s2 [3];
	logic signed [CW-1:0] c_s3 [9];
	logic signed [W-1:0]  a_s3 [3];
	logic signed [CW-1:0] c_s4 [9];
	logic signed [CW-1:0] lo_s4 [3];
	logic signed [CW-1:0] hi_s4 [3];
	logic signed [CW-1:0] c_s5 [9];
	logic signed [TW-1:0] t_s5 [3];
	logic signed [CW-1:0] c_s6 [9];
	logic signed [DW-1:0] det_s6;
	logic [CW-1:0]        nmag_s7 [9];
	logic                 neg_s7 [9];
	logic [DW-1:0]        dmag_s7;
	logic                 sing_s7;

	// front stages: products, cofactors, determinant, magnitudes
	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++) begin
			a_s1[i] <= a_in[i];
		end
		// stage 2: eighteen entry products
		for (int k = 0; k < 18; k++) begin
			p_s2[k] <= PW'(a_s1[PA[k]]) * PW'(a_s1[PB[k]]);
		end
		for (int j = 0; j < 3; j++) begin
			a_s2[j] <= a_s1[j];
		end
		// stage 3: cofactors
		for (int i = 0; i < 9; i++) begin
			c_s3[i] <= CW'(p_s2[2*i]) - CW'(p_s2[2*i+1]);
		end
		for (int j = 0; j < 3; j++) begin
			a_s3[j] <= a_s2[j];
		end
		// stage 4: first-row entry times split cofactor
		for (int j = 0; j < 3; j++) begin
			lo_s4[j] <= CW'(a_s3[j]) * $signed({1'b0, c_s3[DC[j]][W-1:0]});
			hi_s4[j] <= CW'(a_s3[j]) * CW'($signed(c_s3[DC[j]][CW-1:W]));
		end
		c_s4 <= c_s3;
		// stage 5: recombine partial products
		for (int j = 0; j < 3; j++) begin
			t_s5[j] <= (TW'(hi_s4[j]) <<< W) + TW'(lo_s4[j]);
		end
		c_s5 <= c_s4;
		// stage 6: determinant
		det_s6 <= DW'(t_s5[0]) + DW'(t_s5[1]) + DW'(t_s5[2]);
		c_s6   <= c_s5;
		// stage 7: magnitudes and signs
		dmag_s7 <= det_s6[DW-1] ? DW'(-det_s6) : DW'(det_s6);
		sing_s7 <= (det_s6 == '0);
		for (int i = 0; i < 9; i++) begin
			nmag_s7[i] <= c_s6[i][CW-1] ? CW'(-c_s6[i]) : CW'(c_s6[i]);
			neg_s7[i]  <= c_s6[i][CW-1] ^ det_s6[DW-1];
		end
	end

	// divider lanes: entry stage plus one quotient bit per stage
	logic          dv_v    [W+1];
	logic [DW-1:0] dv_d    [W+1];
	logic          dv_sing [W+1];
	logic [XW-1:0] dv_rem  [W+1][9];
	logic [W-1:0]  dv_q    [W+1][9];
	logic          dv_neg  [W+1][9];
	logic          dv_ovf  [W+1][9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else begin
			dv_v[0] <= v_s7;
		end
	end

	// entry stage: scaled numerator and range check
	always_ff @(posedge clk) begin
		dv_d[0]    <= dmag_s7;
		dv_sing[0] <= sing_s7;
		for (int i = 0; i < 9; i++) begin
			dv_rem[0][i] <= XW'(nmag_s7[i]) << (2 * FRAC_BITS);
			dv_q[0][i]   <= '0;
			dv_neg[0][i] <= neg_s7[i];
			dv_ovf[0][i] <= (XW'(nmag_s7[i]) << (2 * FRAC_BITS)) >= (XW'(dmag_s7) << W);
		end
	end

	for (genvar j = 0; j < W; j++) begin : g_step
		localparam int K = W - 1 - j;

		logic [XW-1:0] sub;

		assign sub = XW'(dv_d[j]) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else begin
				dv_v[j+1] <= dv_v[j];
			end
		end

		// restoring step for quotient bit K
		always_ff @(posedge clk) begin
			dv_d[j+1]    <= dv_d[j];
			dv_sing[j+1] <= dv_sing[j];
			for (int i = 0; i < 9; i++) begin
				dv_neg[j+1][i] <= dv_neg[j][i];
				dv_ovf[j+1][i] <= dv_ovf[j][i];
				if (dv_rem[j][i] >= sub) begin
					dv_rem[j+1][i]  <= dv_rem[j][i] - sub;
					dv_q[j+1][i]    <= dv_q[j][i] | (W'(1) << K);
				end else begin
					dv_rem[j+1][i]  <= dv_rem[j][i];
					dv_q[j+1][i]    <= dv_q[j][i];
				end
			end
		end
	end

	// saturate, apply sign, zero singular items
	logic [W-1:0] r_fin [9];

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			if (dv_sing[W]) begin
				r_fin[i] = '0;
			end else if (dv_neg[W][i]) begin
				if (dv_ovf[W][i] || dv_q[W][i] > LIM_NEG) begin
					r_fin[i] = LIM_NEG;
				end else begin
					r_fin[i] = W'(-dv_q[W][i]);
				end
			end else begin
				if (dv_ovf[W][i] || dv_q[W][i] > LIM_POS) begin
					r_fin[i] = LIM_POS;
				end else begin
					r_fin[i] = dv_q[W][i];
				end
			end
		end
	end

	// output register
	logic    done_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_v[W];
		end
	end

	always_ff @(posedge clk) begin
		res_q.r00      <= r_fin[0];
		res_q.r01      <= r_fin[1];
		res_q.r02      <= r_fin[2];
		res_q.r10      <= r_fin[3];
		res_q.r11      <= r_fin[4];
		res_q.r12      <= r_fin[5];
		res_q.r20      <= r_fin[6];
		res_q.r21      <= r_fin[7];
		res_q.r22      <= r_fin[8];
		res_q.singular <= dv_sing[W];
	end

	assign done   = done_q;
	assign result = res_q;

	// checks
	`M3INV_ASSERT_IMP(a_latency, done, $past(start, LAT))
	`M3INV_ASSERT_IMP(a_singular_zero, done && result.singular, result[$bits(result_t)-1:1] == '0)
	`M3INV_ASSERT_NEXT(a_singular_flow, dv_v[W] && dv_sing[W], done && result.singular)

endmodule

// File: tb/tb_matrix3_inverse_unit.sv
// testbench of the 3x3 fixed-point matrix inverse unit
`timescale 1ns / 100ps

module tb_matrix3_inverse_unit;
	import m3inv_pkg::*;

	localparam int FRAC = 16;
	localparam int TAIL_CYCLES = 60;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 1530;
	localparam int CALM_TAIL = 200;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	operand_t operand;
	logic done;
	result_t result;

	operand_t matrix_q[$];
	result_t inverse_q[$];
	int mismatches = 0;
	int results_seen = 0;
	int singular_seen = 0;
	int saturated_seen = 0;
	int cycles = 0;
	int gap = 0;

	matrix3_inverse_unit #(.FRAC_BITS(FRAC)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operand(operand),
		.done(done),
		.result(result)
	);

	// clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// one inverse entry: cofactor scaled by 2^(2F) over the determinant, saturated
	function automatic logic signed [ENTRY_W-1:0] entry_div(logic signed [255:0] cof,
			logic signed [255:0] det);
		logic [255:0] num;
		logic [255:0] den;
		logic [255:0] quo;
		logic neg;
		neg = cof[255] ^ det[255];
		num = (cof[255] ? -cof : cof) << (2 * FRAC);
		den = det[255] ? -det : det;
		quo = num / den;
		if (neg) begin
			if (quo > (256'd1 << (ENTRY_W - 1)))
				quo = 256'd1 << (ENTRY_W - 1);
			return ENTRY_W'(-quo);
		end
		if (quo > ((256'd1 << (ENTRY_W - 1)) - 1))
			quo = (256'd1 << (ENTRY_W - 1)) - 1;
		return ENTRY_W'(quo);
	endfunction

	// adjugate over determinant, exact at wide width
	function automatic result_t invert(operand_t m);
		logic signed [255:0] x00, x01, x02, x10, x11, x12, x20, x21, x22;
		logic signed [255:0] c00, c01, c02, c10, c11, c12, c20, c21, c22, det;
		result_t r;
		x00 = m.a00; x01 = m.a01; x02 = m.a02;
		x10 = m.a10; x11 = m.a11; x12 = m.a12;
		x20 = m.a20; x21 = m.a21; x22 = m.a22;
		c00 = x11 * x22 - x21 * x12;
		c01 = x02 * x21 - x01 * x22;
		c02 = x01 * x12 - x02 * x11;
		c10 = x12 * x20 - x10 * x22;
		c11 = x00 * x22 - x02 * x20;
		c12 = x10 * x02 - x00 * x12;
		c20 = x10 * x21 - x20 * x11;
		c21 = x20 * x01 - x00 * x21;
		c22 = x00 * x11 - x10 * x01;
		det = x00 * c00 + x01 * c10 + x02 * c20;
		r = '0;
		if (det == 0) begin
			r.singular = 1'b1;
			return r;
		end
		r.r00 = entry_div(c00, det); r.r01 = entry_div(c01, det);
		r.r02 = entry_div(c02, det); r.r10 = entry_div(c10, det);
		r.r11 = entry_div(c11, det); r.r12 = entry_div(c12, det);
		r.r20 = entry_div(c20, det); r.r21 = entry_div(c21, det);
		r.r22 = entry_div(c22, det);
		return r;
	endfunction

	task automatic report(string field, logic [ENTRY_W-1:0] got, logic [ENTRY_W-1:0] want);
		$display("mismatch on result %0d field %s: got %h want %h", results_seen, field,
			got, want);
		mismatches++;
	endtask

	// random entry: full range, near unity, or tiny
	function automatic logic [ENTRY_W-1:0] rand_entry(int style);
		case (style)
			0: return $urandom;
			1: return ENTRY_W'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
			default: return ENTRY_W'($signed($urandom_range(0, 16)) - 8);
		endcase
	endfunction

	function automatic operand_t rand_matrix();
		operand_t m;
		int style;
		int shape;
		style = $urandom_range(0, 2);
		shape = $urandom_range(0, 9);
		m = {rand_entry(style), rand_entry(style), rand_entry(style),
			rand_entry(style), rand_entry(style), rand_entry(style),
			rand_entry(style), rand_entry(style), rand_entry(style)};
		// shapes: repeated row and zero column (singular), random diagonal
		if (shape == 0) begin
			m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
		end else if (shape == 1) begin
			m.a01 = '0; m.a11 = '0; m.a21 = '0;
		end else if (shape == 2) begin
			m = '0;
			m.a00 = rand_entry(style); m.a11 = rand_entry(style); m.a22 = rand_entry(style);
		end
		return m;
	endfunction

	function automatic operand_t diag(logic [ENTRY_W-1:0] d0, logic [ENTRY_W-1:0] d1,
			logic [ENTRY_W-1:0] d2);
		operand_t m;
		m = '0;
		m.a00 = d0; m.a11 = d1; m.a22 = d2;
		return m;
	endfunction

	// directed and random items
	task automatic fill_items();
		operand_t m;
		matrix_q.push_back(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
		matrix_q.push_back('0);
		matrix_q.push_back(diag(32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000));
		matrix_q.push_back(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
		matrix_q.push_back(diag(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001));
		matrix_q.push_back(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		matrix_q.push_back(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		matrix_q.push_back({9{32'h7FFF_FFFF}});
		matrix_q.push_back({9{32'h8000_0000}});
		m = {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
		matrix_q.push_back(m);
		m = {32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0,
			32'h0000_0001};
		matrix_q.push_back(m);
		// permutation and mixed-sign matrices
		m = {32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000,
			32'h0, 32'h0};
		matrix_q.push_back(m);
		m = {32'h0002_0000, 32'hFFFF_0000, 32'h0, 32'hFFFF_0000, 32'h0002_0000,
			32'hFFFF_0000, 32'h0, 32'hFFFF_0000, 32'h0002_0000};
		matrix_q.push_back(m);
		m = {32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000,
			32'h0006_0000, 32'h0007_0000, 32'h0008_0000, 32'h0009_0000};
		matrix_q.push_back(m);
		matrix_q.push_back({9{32'h5555_5555}});
		m = {32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0,
			32'h0, 32'h0, 32'hFFFF_FFFF};
		matrix_q.push_back(m);
		for (int i = 0; i < RANDOM_ITEMS; i++)
			matrix_q.push_back(rand_matrix());
	endtask

	// driver: present items, idle in bursts until the calm tail
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			operand <= '0;
			gap <= 0;
		end else begin
			if (start && !busy)
				inverse_q.push_back(invert(operand));
			if (start && busy) begin
				start <= 1'b1;
			end else if (gap > 0) begin
				start <= 1'b0;
				gap <= gap - 1;
			end else if (matrix_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
				start <= 1'b0;
				gap <= $urandom_range(0, 5);
			end else if (matrix_q.size() > 0) begin
				operand <= matrix_q.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: compare each result with the oldest expected inverse
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (inverse_q.size() == 0) begin
				$display("unexpected result %0d", results_seen);
				mismatches++;
			end else begin
				want = inverse_q.pop_front();
				if (result.r00 !== want.r00) report("r00", result.r00, want.r00);
				if (result.r01 !== want.r01) report("r01", result.r01, want.r01);
				if (result.r02 !== want.r02) report("r02", result.r02, want.r02);
				if (result.r10 !== want.r10) report("r10", result.r10, want.r10);
				if (result.r11 !== want.r11) report("r11", result.r11, want.r11);
				if (result.r12 !== want.r12) report("r12", result.r12, want.r12);
				if (result.r20 !== want.r20) report("r20", result.r20, want.r20);
				if (result.r21 !== want.r21) report("r21", result.r21, want.r21);
				if (result.r22 !== want.r22) report("r22", result.r22, want.r22);
				if (result.singular !== want.singular)
					report("singular", ENTRY_W'(result.singular), ENTRY_W'(want.singular));
				if (want.singular)
					singular_seen++;
				if (want.r00 == 32'h7FFF_FFFF || want.r00 == 32'h8000_0000)
					saturated_seen++;
			end
			results_seen++;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// reset, stimulus, drain and verdict
	initial begin
		arst_n = 1'b0;
		fill_items();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (matrix_q.size() == 0 && !start && inverse_q.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("checked %0d inverses: %0d singular, %0d with saturated r00",
			results_seen, singular_seen, saturated_seen);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
